[sv/assert_macros.svh]
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define B64_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define B64_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/b64ld_pkg.sv]
`default_nettype none
package b64ld_pkg;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [6:0] PAD_VALUE = 7'd64;
   localparam logic [9:0] COUNT_MAX = 10'd1023;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_PART = 2'd1,
      STATUS_NONE = 2'd2
   } line_status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic [1:0] line_status;
      logic [9:0] byte_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      rsp_type [3:0] ent;
      logic [2:0]    n;
   } batch_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] val;
   } sextet_type;

   function automatic sextet_type map_char(input logic [7:0] ch);
      sextet_type r;
      logic [7:0] t;
      r = '0;
      t = '0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         t = ch - 8'h41;
         r = '{ok: 1'b1, val: t[6:0]};
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         t = ch - 8'h47;
         r = '{ok: 1'b1, val: t[6:0]};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         t = ch + 8'h04;
         r = '{ok: 1'b1, val: t[6:0]};
      end else if (ch == 8'h2B) begin
         r = '{ok: 1'b1, val: 7'd62};
      end else if (ch == 8'h2F) begin
         r = '{ok: 1'b1, val: 7'd63};
      end else if (ch == 8'h3D) begin
         r = '{ok: 1'b1, val: PAD_VALUE};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/b64ld_req_if.sv]
`default_nettype none
interface b64ld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_line;

   modport source (output valid, output in_char, output end_of_line, input ready);
   modport sink   (input valid, input in_char, input end_of_line, output ready);
endinterface
`default_nettype wire

[sv/b64ld_rsp_if.sv]
`default_nettype none
interface b64ld_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_byte;
   logic [1:0] line_status;
   logic [9:0] byte_count;
   logic       last;

   modport source (output valid, output kind, output out_byte, output line_status,
                   output byte_count, output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input line_status,
                   input byte_count, input last, output ready);
endinterface
`default_nettype wire

[sv/b64ld_group_decode.sv]
`default_nettype none
module b64ld_group_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_accept,
   input  wire logic [7:0]        in_char,
   input  wire logic              end_of_line,
   output b64ld_pkg::batch_type   batch
);
   import b64ld_pkg::*;

   logic [1:0]      pos_ff, pos_in;
   logic [2:0][6:0] sextet_ff, sextet_in;
   logic [2:0]      marks_ff, marks_in;
   logic            stopped_ff, stopped_in;
   logic            error_ff, error_in;
   logic [9:0]      bytes_ff, bytes_in;

   sextet_type      mapped;
   logic [6:0]      a, b, c, d;
   logic [13:0]     ab;
   logic [19:0]     abc;
   logic [7:0]      byte1, byte2, byte3;
   logic [1:0]      nb;
   logic [10:0]     sum;
   logic [2:0]      n;
   logic [1:0]      last_idx;
   line_status_type status;

   always_comb begin
      mapped     = map_char(in_char);
      pos_in     = pos_ff;
      sextet_in  = sextet_ff;
      marks_in   = marks_ff;
      stopped_in = stopped_ff;
      error_in   = error_ff;
      a          = sextet_ff[0];
      b          = sextet_ff[1];
      c          = sextet_ff[2];
      d          = mapped.val;
      ab         = {a, 6'b0} | {7'b0, b};
      abc        = {ab, 6'b0} | {13'b0, c};
      byte1      = ab[11:4];
      byte2      = abc[9:2];
      byte3      = '0;
      nb         = 2'd0;
      if (!stopped_ff) begin
         if (pos_ff != 2'd3) begin
            sextet_in[pos_ff] = mapped.val;
            marks_in[pos_ff]  = ~mapped.ok;
            pos_in            = pos_ff + 2'd1;
         end else begin
            stopped_in = 1'b1;
            pos_in     = 2'd0;
            marks_in   = '0;
            if (marks_ff[0]) begin
               error_in = 1'b1;
            end else if (marks_ff[1]) begin
               error_in = 1'b1;
               byte1    = {a[5:0], 2'b00};
               nb       = 2'd1;
            end else if (marks_ff[2]) begin
               error_in = 1'b1;
               nb       = 2'd1;
            end else begin
               if (!mapped.ok) begin
                  error_in = 1'b1;
                  d        = PAD_VALUE;
               end
               byte3 = {abc[1:0], 6'b0} | {1'b0, d};
               nb    = 2'd1;
               if (!c[6]) begin
                  nb = 2'd2;
                  if (!d[6]) begin
                     nb         = 2'd3;
                     stopped_in = 1'b0;
                  end
               end
            end
         end
      end
      sum      = {1'b0, bytes_ff} + {9'b0, nb};
      bytes_in = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[9:0];
      status   = STATUS_OK;
      if (error_in) begin
         status = (bytes_in == 10'd0) ? STATUS_NONE : STATUS_PART;
      end

      batch.ent[0] = '{kind: KIND_DATA, out_byte: byte1, line_status: '0,
                       byte_count: '0, last: 1'b0};
      batch.ent[1] = '{kind: KIND_DATA, out_byte: byte2, line_status: '0,
                       byte_count: '0, last: 1'b0};
      batch.ent[2] = '{kind: KIND_DATA, out_byte: byte3, line_status: '0,
                       byte_count: '0, last: 1'b0};
      batch.ent[3] = '0;
      n            = {1'b0, nb};
      if (end_of_line) begin
         batch.ent[nb] = '{kind: KIND_STATUS, out_byte: '0, line_status: status,
                           byte_count: bytes_in, last: 1'b0};
         n          = {1'b0, nb} + 3'd1;
         pos_in     = '0;
         sextet_in  = '0;
         marks_in   = '0;
         stopped_in = 1'b0;
         error_in   = 1'b0;
         bytes_in   = '0;
      end
      last_idx = n[1:0] - 2'd1;
      if (n != 3'd0) begin
         batch.ent[last_idx].last = 1'b1;
      end
      batch.n = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sextet_ff  <= '0;
         marks_ff   <= '0;
         stopped_ff <= 1'b0;
         error_ff   <= 1'b0;
         bytes_ff   <= '0;
      end else if (req_accept) begin
         pos_ff     <= pos_in;
         sextet_ff  <= sextet_in;
         marks_ff   <= marks_in;
         stopped_ff <= stopped_in;
         error_ff   <= error_in;
         bytes_ff   <= bytes_in;
      end
   end

endmodule
`default_nettype wire

[sv/b64ld_rsp_queue.sv]
`default_nettype none
module b64ld_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire b64ld_pkg::batch_type batch,
   output logic                     space,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output b64ld_pkg::rsp_type       rsp_head
);
   import b64ld_pkg::*;

   rsp_type [3:0] ent_ff, ent_in;
   logic [2:0]    rem_ff, rem_in;
   logic          take;

   always_comb begin
      rsp_valid = (rem_ff != 3'd0);
      rsp_head  = ent_ff[0];
      take      = rsp_valid & rsp_ready;
      space     = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && take);
      ent_in    = ent_ff;
      rem_in    = rem_ff;
      if (load) begin
         ent_in = batch.ent;
         rem_in = batch.n;
      end else if (take) begin
         ent_in = {rsp_type'('0), ent_ff[3:1]};
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule
`default_nettype wire

[sv/base64_line_decoder_core.sv]
// channel   dir  signals                                          role
// req_if    in   valid ready in_char end_of_line                  encoded characters
// rsp_if    out  valid ready kind out_byte line_status byte_count last  bytes and status
//
// one character is taken per clock while its results fit the output queue
// a character gives zero to four results, sent one per clock from the queue while rsp_if is ready
// the next character is taken in the cycle the last queued result transfers
// reset is synchronous and clears the line state and the queue
// a stalled rsp_if holds its result and stops req_if
`default_nettype none
module base64_line_decoder_core (
   input  wire logic      clock,
   input  wire logic      reset,
   b64ld_req_if.sink      req_if,
   b64ld_rsp_if.source    rsp_if
);
   import b64ld_pkg::*;

   batch_type batch;
   rsp_type   head;
   logic      space;
   logic      req_accept;

   assign req_if.ready = space;
   assign req_accept   = req_if.valid & space;

   b64ld_group_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .in_char     (req_if.in_char),
      .end_of_line (req_if.end_of_line),
      .batch       (batch)
   );

   b64ld_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .batch     (batch),
      .space     (space),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_head  (head)
   );

   assign rsp_if.kind        = head.kind;
   assign rsp_if.out_byte    = head.out_byte;
   assign rsp_if.line_status = head.line_status;
   assign rsp_if.byte_count  = head.byte_count;
   assign rsp_if.last        = head.last;

endmodule
`default_nettype wire

[sv/b64ld_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module b64ld_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_eol,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte,
   input wire logic [9:0] rsp_count
);

   // nothing left over from before reset
   `B64_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled result holds
   `B64_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_byte) && $stable(rsp_count))

   // a blocked output queue stops intake
   `B64_ASSERT_IMP(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // the end of a line always yields a valid result next
   `B64_ASSERT_NXT(a_eol_result, clock, reset, req_valid && req_ready && req_eol,
                   rsp_valid)

endmodule

bind base64_line_decoder_core b64ld_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_eol   (req_if.end_of_line),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_byte  (rsp_if.out_byte),
   .rsp_count (rsp_if.byte_count)
);
`default_nettype wire
